@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/clws_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package clws_pkg;

  // request kinds
  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_RAW  = 2'd1;
  localparam logic [1:0] OP_CHAR = 2'd2;
  localparam logic [1:0] OP_NUM  = 2'd3;

  localparam int MAX_DIGITS = 5;
  localparam int NUM_W      = 16;
  localparam int BCD_DIGITS = 5;                  // enough for any 16-bit value
  localparam int DD_W       = NUM_W + 4 * BCD_DIGITS;
  localparam int CONV_CNT_W = $clog2(NUM_W);
  localparam int BIDX_W     = 4;                  // up to 2*MAX_DIGITS bytes

  localparam logic [7:0]  CMD_FUNC_8BIT = 8'h38;
  localparam logic [7:0]  CMD_FUNC_4BIT = 8'h28;
  localparam logic [7:0]  CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0]  CMD_ENTRY     = 8'h06;
  localparam logic [7:0]  CMD_CLEAR     = 8'h01;
  localparam logic [7:0]  CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0]  LINE2_BASE    = 8'h40;
  localparam logic [3:0]  ASCII_DIGIT   = 4'h3;

  localparam logic [14:0] WAIT_POWER_UP = 15'd20000;
  localparam logic [12:0] WAIT_BYTE     = 13'd100;
  localparam logic [12:0] WAIT_NIBBLE   = 13'd50;
  localparam logic [12:0] WAIT_CLEAR    = 13'd2000;

  typedef struct packed {
    logic [7:0]  data;
    logic        lone;       // single nibble, no low half
    logic [12:0] wait_lone;  // settle time for a single nibble
    logic [12:0] extra;      // added after the final half of a byte
  } init_ent_t;

  typedef struct packed {
    logic              load;
    logic              conv;
    logic              emit;
    logic              phase;  // 0 high nibble, 1 low nibble
    logic              last;
    logic [BIDX_W-1:0] bidx;
  } cmd_t;

  typedef struct packed {
    logic              mode;   // 1 = 4-bit bus
    logic              lone;
    logic [BIDX_W-1:0] n_bytes;
  } sts_t;

  // Init list: entries 0..3 are the 4-bit wake-up nibbles, 4..7 the bytes.
  function automatic init_ent_t init_entry(input logic [2:0] j, input logic mode);
    init_ent_t e;
    e = '{data: 8'h00, lone: 1'b0, wait_lone: 13'd0, extra: 13'd0};
    case (j)
      3'd0: e = '{data: 8'h30, lone: 1'b1, wait_lone: 13'd5000, extra: 13'd0};
      3'd1: e = '{data: 8'h30, lone: 1'b1, wait_lone: 13'd5000, extra: 13'd0};
      3'd2: e = '{data: 8'h30, lone: 1'b1, wait_lone: 13'd150, extra: 13'd0};
      3'd3: e = '{data: 8'h20, lone: 1'b1, wait_lone: 13'd0, extra: 13'd0};
      3'd4: e = '{data: mode ? CMD_FUNC_4BIT : CMD_FUNC_8BIT, lone: 1'b0,
                  wait_lone: 13'd0, extra: 13'd0};
      3'd5: e.data = CMD_DISP_ON;
      3'd6: e.data = CMD_ENTRY;
      3'd7: e = '{data: CMD_CLEAR, lone: 1'b0, wait_lone: 13'd0, extra: WAIT_CLEAR};
      default: e = '{data: 8'h00, lone: 1'b0, wait_lone: 13'd0, extra: 13'd0};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

@@ design/clws_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clws_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [1:0]      opcode_i,
  input  wire clws_pkg::sts_t  sts_i,
  output clws_pkg::cmd_t       cmd_o,
  output logic                 busy_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [clws_pkg::CONV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [clws_pkg::BIDX_W-1:0]         bidx_q, bidx_d;
  logic                                phase_q, phase_d;
  logic                                done_byte;
  logic                                last_byte;

  assign done_byte = sts_i.lone || !sts_i.mode || phase_q;
  assign last_byte = (bidx_q == (sts_i.n_bytes - clws_pkg::BIDX_W'(1)));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bidx_d  = bidx_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.bidx  = bidx_q;
    cmd_o.phase = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          bidx_d     = '0;
          phase_d    = 1'b0;
          state_d    = (opcode_i == clws_pkg::OP_NUM) ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == clws_pkg::CONV_CNT_W'(clws_pkg::NUM_W - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (bidx_q >= sts_i.n_bytes) begin
          // empty number request
          state_d = ST_IDLE;
        end else begin
          cmd_o.emit = 1'b1;
          cmd_o.last = last_byte && done_byte;
          if (done_byte) begin
            bidx_d  = bidx_q + 1'b1;
            phase_d = 1'b0;
          end else begin
            phase_d = 1'b1;
          end
          if (last_byte && done_byte) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bidx_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bidx_q  <= bidx_d;
      phase_q <= phase_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ design/clws_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clws_dpath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_data_i,
  input  wire logic [1:0]      opcode_i,
  input  wire logic [1:0]      line_no_i,
  input  wire logic [5:0]      column_no_i,
  input  wire logic [7:0]      byte_value_i,
  input  wire logic [15:0]     number_value_i,
  input  wire logic [2:0]      digit_count_i,
  input  wire clws_pkg::cmd_t  cmd_i,
  output clws_pkg::sts_t       sts_o,
  output logic                 res_strobe_o,
  output logic                 reg_select_o,
  output logic [7:0]           bus_data_o,
  output logic [14:0]          wait_before_us_o,
  output logic [12:0]          wait_after_us_o,
  output logic                 last_o
);

  logic                          mode_q;
  logic [1:0]                    op_q;
  logic                          line2_q;
  logic [5:0]                    col_q;
  logic [7:0]                    byte_q;
  logic [2:0]                    cnt_q;
  logic [clws_pkg::DD_W-1:0]     dd_q, dd_d;
  logic [clws_pkg::DD_W-1:0]     dd_adj;
  logic [3:0]                    digs [clws_pkg::BCD_DIGITS];

  logic [2:0]                    pair;
  logic [2:0]                    dig_idx;
  logic [7:0]                    col8;
  logic [7:0]                    addr_cmd;
  logic [2:0]                    init_j;
  clws_pkg::init_ent_t           ient;
  logic [7:0]                    cur_byte;
  logic                          cur_rs;
  logic [12:0]                   cur_extra;
  logic [7:0]                    data_d;
  logic [12:0]                   after_d;
  logic [14:0]                   before_d;

  logic                          strobe_q;
  logic                          rs_q, last_q;
  logic [7:0]                    data_q;
  logic [14:0]                   before_q;
  logic [12:0]                   after_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // double dabble: add 3 to digits of 5 and up, then shift
  always_comb begin
    dd_adj = dd_q;
    for (int k = 0; k < clws_pkg::BCD_DIGITS; k++) begin
      if (dd_q[clws_pkg::NUM_W + 4*k +: 4] >= 4'd5) begin
        dd_adj[clws_pkg::NUM_W + 4*k +: 4] = dd_q[clws_pkg::NUM_W + 4*k +: 4] + 4'd3;
      end
    end
    dd_d = {dd_adj[clws_pkg::DD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      line2_q <= (line_no_i == 2'd2);
      col_q   <= column_no_i;
      byte_q  <= byte_value_i;
      cnt_q   <= (digit_count_i > 3'(clws_pkg::MAX_DIGITS)) ?
                 3'(clws_pkg::MAX_DIGITS) : digit_count_i;
      dd_q    <= {(clws_pkg::DD_W - clws_pkg::NUM_W)'(0), number_value_i};
    end else if (cmd_i.conv) begin
      dd_q    <= dd_d;
    end
  end

  always_comb begin
    for (int k = 0; k < clws_pkg::BCD_DIGITS; k++) begin
      digs[k] = dd_q[clws_pkg::NUM_W + 4*k +: 4];
    end
  end

  // byte pair p holds the address command and the character of digit p, counted from the left
  assign pair     = cmd_i.bidx[3:1];
  assign dig_idx  = cnt_q - 3'd1 - pair;
  assign col8     = {2'b00, col_q} + {5'b00000, pair};
  assign addr_cmd = clws_pkg::CMD_SET_DDRAM |
                    (col8 - 8'd1 + (line2_q ? clws_pkg::LINE2_BASE : 8'h00));

  assign init_j = mode_q ? cmd_i.bidx[2:0] : {1'b1, cmd_i.bidx[1:0]};
  assign ient   = clws_pkg::init_entry(init_j, mode_q);

  always_comb begin
    cur_byte  = byte_q;
    cur_rs    = 1'b0;
    cur_extra = 13'd0;
    sts_o.mode    = mode_q;
    sts_o.n_bytes = '0;
    sts_o.lone    = 1'b0;
    case (op_q)
      clws_pkg::OP_INIT: begin
        cur_byte      = ient.data;
        cur_extra     = ient.extra;
        sts_o.lone    = ient.lone;
        sts_o.n_bytes = mode_q ? clws_pkg::BIDX_W'(8) : clws_pkg::BIDX_W'(4);
      end
      clws_pkg::OP_RAW: begin
        sts_o.n_bytes = clws_pkg::BIDX_W'(1);
      end
      clws_pkg::OP_CHAR: begin
        cur_byte      = cmd_i.bidx[0] ? byte_q : addr_cmd;
        cur_rs        = cmd_i.bidx[0];
        sts_o.n_bytes = clws_pkg::BIDX_W'(2);
      end
      clws_pkg::OP_NUM: begin
        cur_byte      = cmd_i.bidx[0] ? {clws_pkg::ASCII_DIGIT, digs[dig_idx]} : addr_cmd;
        cur_rs        = cmd_i.bidx[0];
        sts_o.n_bytes = {cnt_q, 1'b0};
      end
      default: sts_o.n_bytes = '0;
    endcase
  end

  always_comb begin
    if (sts_o.lone) begin
      data_d  = cur_byte;
      after_d = ient.wait_lone;
    end else if (!mode_q) begin
      data_d  = cur_byte;
      after_d = clws_pkg::WAIT_BYTE + cur_extra;
    end else if (!cmd_i.phase) begin
      data_d  = {cur_byte[7:4], 4'h0};
      after_d = clws_pkg::WAIT_NIBBLE;
    end else begin
      data_d  = {cur_byte[3:0], 4'h0};
      after_d = clws_pkg::WAIT_NIBBLE + cur_extra;
    end
    before_d = ((op_q == clws_pkg::OP_INIT) && (cmd_i.bidx == '0) && !cmd_i.phase) ?
               clws_pkg::WAIT_POWER_UP : 15'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rs_q     <= cur_rs;
      data_q   <= data_d;
      before_q <= before_d;
      after_q  <= after_d;
      last_q   <= cmd_i.last;
    end
  end

  assign res_strobe_o     = strobe_q;
  assign reg_select_o     = rs_q;
  assign bus_data_o       = data_q;
  assign wait_before_us_o = before_q;
  assign wait_after_us_o  = after_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

@@ design/char_lcd_write_sequencer.sv @@
`timescale 1ns / 1ps
// Flow: a taken request moves the controller out of idle, and each transfer is then
//   registered onto the result ports; a number request first runs binary-to-BCD
//   conversion (one bit per cycle). Throughput: one transfer per cycle once emitting;
//   up to 12 for init, 20 for a 5-digit number on 4-bit bus, none with no digits.
// Results are shown for one cycle with res_strobe_o; the receiver cannot stall.
// Reset (rst_ni low, async): sequencer idle, no strobe, bus_mode back to 8-bit.
`default_nettype none

module char_lcd_write_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [1:0]  line_no_i,
  input  wire logic [5:0]  column_no_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [15:0] number_value_i,
  input  wire logic [2:0]  digit_count_i,
  // bus_mode register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  // transfers
  output logic             res_strobe_o,
  output logic             reg_select_o,
  output logic [7:0]       bus_data_o,
  output logic [14:0]      wait_before_us_o,
  output logic [12:0]      wait_after_us_o,
  output logic             last_o
);

  clws_pkg::cmd_t cmd;
  clws_pkg::sts_t sts;
  logic           busy_int;

  // Controller walks the byte list of the request (index + nibble phase);
  // while idle it only looks at start, so start while busy is ignored.
  // A new request can be taken in the first cycle in which busy is low.
  clws_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start && !busy_int),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_int)
  );

  // Datapath latches the request, converts the number to BCD, builds each
  // transfer (address command, character, nibble split, settle waits) and
  // registers it onto the result ports.
  clws_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .line_no_i        (line_no_i),
    .column_no_i      (column_no_i),
    .byte_value_i     (byte_value_i),
    .number_value_i   (number_value_i),
    .digit_count_i    (digit_count_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .res_strobe_o     (res_strobe_o),
    .reg_select_o     (reg_select_o),
    .bus_data_o       (bus_data_o),
    .wait_before_us_o (wait_before_us_o),
    .wait_after_us_o  (wait_after_us_o),
    .last_o           (last_o)
  );

  // bus mode only changes between requests
  assign cfg_ready_o = !busy_int;
  assign busy        = busy_int;

endmodule

`default_nettype wire

@@ design/clws_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clws_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        res_strobe_o,
  input wire logic        reg_select_o,
  input wire logic [14:0] wait_before_us_o,
  input wire logic        last_o
);

  // a taken request makes the sequencer busy
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "request not taken")
  // the final transfer of a request is not directly followed by another
  `ASSERT_NEXT(a_last_gap, clk_i, rst_ni, res_strobe_o && last_o, !res_strobe_o, "transfer after last")
  // more transfers pending means the request is still in work
  `ASSERT_IMP(a_mid_busy, clk_i, rst_ni, res_strobe_o && !last_o, busy, "idle before last")
  // only the init instruction carries the power-up wait
  `ASSERT_IMP(a_wait_instr, clk_i, rst_ni, res_strobe_o && (wait_before_us_o != 15'd0), !reg_select_o, "power-up wait on data")

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .res_strobe_o     (res_strobe_o),
  .reg_select_o     (reg_select_o),
  .wait_before_us_o (wait_before_us_o),
  .last_o           (last_o)
);

`default_nettype wire

@@ sim/lcd_xfer_checker.sv @@
`timescale 1ns / 1ps

module lcd_xfer_checker
  import clws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  line_no_i,
  input  logic [5:0]  column_no_i,
  input  logic [7:0]  byte_value_i,
  input  logic [15:0] number_value_i,
  input  logic [2:0]  digit_count_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  input  logic        res_strobe_i,
  input  logic        reg_select_i,
  input  logic [7:0]  bus_data_i,
  input  logic [14:0] wait_before_us_i,
  input  logic [12:0] wait_after_us_i,
  input  logic        last_i,
  output int          mismatches_o,
  output int          outstanding_o,
  output int          xfers_seen_o
);

  typedef struct packed {
    logic        rs;
    logic [7:0]  data;
    logic [14:0] pre_wait;
    logic [12:0] after;
    logic        last;
  } xfer_t;

  xfer_t pending_xfers[$];
  logic  lcd_4bit;
  int    mismatches;
  int    xfers_seen;

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    xfers_seen_o  = 0;
  end

  // one byte, or two nibbles in bits 7:4 on the narrow bus
  function automatic void queue_byte(input logic rs, input logic [7:0] b,
                                     input logic [12:0] extra);
    if (!lcd_4bit) begin
      pending_xfers.push_back('{rs, b, 15'd0, WAIT_BYTE + extra, 1'b0});
    end else begin
      pending_xfers.push_back('{rs, {b[7:4], 4'h0}, 15'd0, WAIT_NIBBLE, 1'b0});
      pending_xfers.push_back('{rs, {b[3:0], 4'h0}, 15'd0, WAIT_NIBBLE + extra, 1'b0});
    end
  endfunction

  function automatic void queue_char(input logic [1:0] line, input logic [7:0] col,
                                     input logic [7:0] ch);
    logic [7:0] addr;
    addr = col - 8'd1;
    if (line == 2'd2) begin
      addr = addr + LINE2_BASE;
    end
    queue_byte(1'b0, CMD_SET_DDRAM | addr, 13'd0);
    queue_byte(1'b1, ch, 13'd0);
  endfunction

  function automatic void predict_transfers(input logic [1:0] op, input logic [1:0] line,
                                            input logic [5:0] col, input logic [7:0] bval,
                                            input logic [15:0] num, input logic [2:0] cnt);
    int          first;
    int          digits;
    int unsigned scale;
    int unsigned digit;
    logic [7:0]  c;
    xfer_t       t;
    first = pending_xfers.size();
    case (op)
      OP_INIT: begin
        if (!lcd_4bit) begin
          queue_byte(1'b0, CMD_FUNC_8BIT, 13'd0);
        end else begin
          // wake-up nibbles before the bus width is set
          pending_xfers.push_back('{1'b0, 8'h30, 15'd0, 13'd5000, 1'b0});
          pending_xfers.push_back('{1'b0, 8'h30, 15'd0, 13'd5000, 1'b0});
          pending_xfers.push_back('{1'b0, 8'h30, 15'd0, 13'd150, 1'b0});
          pending_xfers.push_back('{1'b0, 8'h20, 15'd0, 13'd0, 1'b0});
          queue_byte(1'b0, CMD_FUNC_4BIT, 13'd0);
        end
        queue_byte(1'b0, CMD_DISP_ON, 13'd0);
        queue_byte(1'b0, CMD_ENTRY, 13'd0);
        queue_byte(1'b0, CMD_CLEAR, WAIT_CLEAR);
        t = pending_xfers[first];
        t.pre_wait = WAIT_POWER_UP;
        pending_xfers[first] = t;
      end
      OP_RAW: begin
        queue_byte(1'b0, bval, 13'd0);
      end
      OP_CHAR: begin
        queue_char(line, {2'b00, col}, bval);
      end
      default: begin
        digits = (cnt > MAX_DIGITS) ? MAX_DIGITS : int'(cnt);
        c = {2'b00, col};
        for (int i = digits; i > 0; i--) begin
          scale = 1;
          for (int k = 1; k < i; k++) begin
            scale = scale * 10;
          end
          digit = (int'(num) / scale) % 10;
          queue_char(line, c, {ASCII_DIGIT, digit[3:0]});
          c = c + 8'd1;
        end
      end
    endcase
    if (pending_xfers.size() > first) begin
      t = pending_xfers[$];
      t.last = 1'b1;
      pending_xfers[$] = t;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    xfer_t want;
    xfer_t got;
    if (!rst_ni) begin
      lcd_4bit = 1'b0;
      pending_xfers.delete();
    end else begin
      // compare before predicting: a new request may be taken on the last strobe
      if (res_strobe_i) begin
        got = '{reg_select_i, bus_data_i, wait_before_us_i, wait_after_us_i, last_i};
        xfers_seen++;
        if (pending_xfers.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: transfer with nothing pending: rs=%0d data=%02h before=%0d after=%0d last=%0d",
                     $time, got.rs, got.data, got.pre_wait, got.after, got.last);
          end
          mismatches++;
        end else begin
          want = pending_xfers.pop_front();
          if (got.rs !== want.rs || got.data !== want.data || got.pre_wait !== want.pre_wait ||
              got.after !== want.after || got.last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: transfer mismatch: expected rs=%0d data=%02h before=%0d after=%0d last=%0d",
                       $time, want.rs, want.data, want.pre_wait, want.after, want.last);
              $display("%0t:                      actual rs=%0d data=%02h before=%0d after=%0d last=%0d",
                       $time, got.rs, got.data, got.pre_wait, got.after, got.last);
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        lcd_4bit = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        predict_transfers(opcode_i, line_no_i, column_no_i, byte_value_i, number_value_i,
                          digit_count_i);
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= pending_xfers.size();
    xfers_seen_o  <= xfers_seen;
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  import clws_pkg::*;

  // Slowest legal run is roughly 370 requests, each with an idle gap, BCD
  // conversion and busy time; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT  = 300000;
  // Quiet time after the last transfer: a zero-digit number request still
  // runs its BCD conversion without producing a transfer.
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 87;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  // request channel
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = OP_RAW;
  logic [1:0]  line_no = 2'd1;
  logic [5:0]  column_no = 6'd1;
  logic [7:0]  byte_value = 8'h00;
  logic [15:0] number_value = 16'h0000;
  logic [2:0]  digit_count = 3'd0;

  // bus_mode write channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // transfer outputs
  logic        res_strobe;
  logic        reg_select;
  logic [7:0]  bus_data;
  logic [14:0] wait_before_us;
  logic [12:0] wait_after_us;
  logic        last;

  int mismatches;
  int outstanding;
  int xfers_seen;
  int cycles = 0;
  int req_count [4] = '{0, 0, 0, 0};
  int mode_writes = 0;
  bit no_idle = 1'b0;   // burst stretch: back-to-back requests

  always #5 clk = ~clk;

  char_lcd_write_sequencer DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode),
    .line_no_i        (line_no),
    .column_no_i      (column_no),
    .byte_value_i     (byte_value),
    .number_value_i   (number_value),
    .digit_count_i    (digit_count),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .res_strobe_o     (res_strobe),
    .reg_select_o     (reg_select),
    .bus_data_o       (bus_data),
    .wait_before_us_o (wait_before_us),
    .wait_after_us_o  (wait_after_us),
    .last_o           (last)
  );

  // Watches both input channels and the transfer strobe, predicts and compares.
  lcd_xfer_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .opcode_i         (opcode),
    .line_no_i        (line_no),
    .column_no_i      (column_no),
    .byte_value_i     (byte_value),
    .number_value_i   (number_value),
    .digit_count_i    (digit_count),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .res_strobe_i     (res_strobe),
    .reg_select_i     (reg_select),
    .bus_data_i       (bus_data),
    .wait_before_us_i (wait_before_us),
    .wait_after_us_i  (wait_after_us),
    .last_i           (last),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .xfers_seen_o     (xfers_seen)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transfers still pending", cycles, outstanding);
      $display("[char_lcd_write_sequencer] ERROR");
      $finish;
    end
  end

  // One request: idle for a random gap (none during a burst), then hold start
  // until the edge where busy is low. start is left high on return so a
  // back-to-back request never drops it for a cycle.
  task automatic issue_request(input logic [1:0] op, input logic [1:0] line,
                               input logic [5:0] col, input logic [7:0] bval,
                               input logic [15:0] num, input logic [2:0] cnt);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    line_no      <= line;
    column_no    <= col;
    byte_value   <= bval;
    number_value <= num;
    digit_count  <= cnt;
    do @(posedge clk); while (busy);
    req_count[op]++;
  endtask

  // Let every predicted transfer come out, then give the block time to finish
  // work that makes no transfer, and make sure it reports idle.
  task automatic drain;
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // bus_mode write, only issued after reset or drain
  task automatic write_bus_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // Mostly legal lines, columns and digit counts; now and then the odd values
  // (line 0/3, column 0 or past 40, digit count 0/6/7) that exercise wrapping
  // and saturation.
  task automatic random_request;
    logic [1:0]  op;
    logic [1:0]  line;
    logic [5:0]  col;
    logic [15:0] num;
    logic [2:0]  cnt;
    op   = 2'($urandom_range(0, 3));
    line = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
    col  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 40));
    num  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 99)) : 16'($urandom);
    cnt  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 5));
    issue_request(op, line, col, 8'($urandom), num, cnt);
  endtask

  initial begin
    // Reset held low, then released on a clock edge.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, 8-bit bus ----
    write_bus_mode(1'b0);
    issue_request(OP_INIT, 2'd1, 6'd1, 8'h00, 16'h0000, 3'd0);
    issue_request(OP_RAW, 2'd1, 6'd1, 8'h00, 16'h0000, 3'd0);
    issue_request(OP_RAW, 2'd2, 6'd40, 8'hFF, 16'hFFFF, 3'd7);
    // raw clear gets no extra settle time
    issue_request(OP_RAW, 2'd1, 6'd1, CMD_CLEAR, 16'h0000, 3'd0);
    issue_request(OP_CHAR, 2'd1, 6'd1, 8'h00, 16'h0000, 3'd0);
    issue_request(OP_CHAR, 2'd2, 6'd40, 8'hFF, 16'h0000, 3'd0);
    // column 0 wraps the address on both lines
    issue_request(OP_CHAR, 2'd1, 6'd0, 8'h41, 16'h0000, 3'd0);
    issue_request(OP_CHAR, 2'd2, 6'd0, 8'h42, 16'h0000, 3'd0);
    // line 0 and line 3 count as the first line
    issue_request(OP_CHAR, 2'd0, 6'd5, 8'h55, 16'h0000, 3'd0);
    issue_request(OP_CHAR, 2'd3, 6'd63, 8'hAA, 16'h0000, 3'd0);
    issue_request(OP_NUM, 2'd1, 6'd1, 8'h00, 16'hFFFF, 3'd5);
    issue_request(OP_NUM, 2'd2, 6'd1, 8'h00, 16'h0000, 3'd5);
    // short number: leading zeros fill the missing digits
    issue_request(OP_NUM, 2'd1, 6'd10, 8'h00, 16'd7, 3'd3);
    // zero digits: nothing on the bus
    issue_request(OP_NUM, 2'd1, 6'd1, 8'h00, 16'd123, 3'd0);
    // digit counts above the maximum saturate
    issue_request(OP_NUM, 2'd2, 6'd20, 8'h00, 16'd54321, 3'd6);
    issue_request(OP_NUM, 2'd1, 6'd30, 8'h00, 16'd9999, 3'd7);
    // digits run past the last column and wrap
    issue_request(OP_NUM, 2'd1, 6'd63, 8'h00, 16'd31415, 3'd5);
    issue_request(OP_NUM, 2'd2, 6'd62, 8'h00, 16'd27182, 3'd5);
    drain();

    // ---- directed, 4-bit bus ----
    write_bus_mode(1'b1);
    issue_request(OP_INIT, 2'd2, 6'd40, 8'hFF, 16'hFFFF, 3'd7);
    issue_request(OP_RAW, 2'd1, 6'd1, 8'hA5, 16'h0000, 3'd0);
    issue_request(OP_RAW, 2'd1, 6'd1, CMD_CLEAR, 16'h0000, 3'd0);
    issue_request(OP_CHAR, 2'd2, 6'd17, 8'h5A, 16'h0000, 3'd0);
    issue_request(OP_NUM, 2'd1, 6'd63, 8'h00, 16'd65535, 3'd5);
    issue_request(OP_NUM, 2'd2, 6'd1, 8'h00, 16'd42, 3'd0);

    // ---- random phases, bus width flipped between phases ----
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_bus_mode(phase[0]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 16 == 0) begin
          no_idle = ($urandom_range(0, 3) == 0);
        end
        random_request();
      end
    end
    no_idle = 1'b0;
    drain();

    $display("covered %0d init, %0d raw, %0d char and %0d number requests on both bus widths",
             req_count[OP_INIT], req_count[OP_RAW], req_count[OP_CHAR], req_count[OP_NUM]);
    $display("%0d transfers checked, %0d bus_mode writes, %0d mismatches, %0d left pending",
             xfers_seen, mode_writes, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[char_lcd_write_sequencer] OK");
    end else begin
      $display("[char_lcd_write_sequencer] ERROR");
    end
    $finish;
  end

endmodule
